@@ src/sitoa_pkg.sv @@
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, FSM state type and controller/datapath buses.
// No dependencies.
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 10;             // 2^32 fits in ten decimal digits
    localparam int IDX_W      = 4;              // indexes digits 0..9
    localparam int CNT_W      = 5;              // counts the 32 shift steps

    localparam logic [CHAR_W-1:0] CHR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHR_ZERO  = 6'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_DIGIT
    } fsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture magnitude and sign, clear BCD
        logic shift;        // one shift-add-3 step
        logic prep;         // latch index of the leading digit
        logic dec;          // step to the next lower digit
        logic emit_sign;    // output shows the minus sign
        logic emit_digit;   // output shows the current digit
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic conv_last;    // current shift step is the final one
        logic idx_zero;     // current digit is the least significant
        logic negative;     // value was negative
    } dp_status_t;

endpackage

@@ src/sitoa_value_if.sv @@
// Input channel: one signed 32-bit value per transfer.
// Depends on sitoa_pkg.
interface sitoa_value_if
    import sitoa_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ src/sitoa_char_if.sv @@
// Output channel: one ASCII character per transfer, with a last flag.
// Depends on sitoa_pkg.
interface sitoa_char_if
    import sitoa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ src/sitoa_datapath.sv @@
// Datapath: magnitude shift register, BCD shift-add-3 converter, digit index.
// Depends on sitoa_pkg.
module sitoa_datapath
    import sitoa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    output logic [CHAR_W-1:0]         char_code,
    output logic                      last
);

    logic [VALUE_W-1:0]                mag_reg, mag_next;
    logic                              neg_reg, neg_next;
    logic [NUM_DIGITS-1:0][3:0]        bcd_reg, bcd_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [NUM_DIGITS-1:0][3:0]        bcd_adj;
    logic [NUM_DIGITS*4-1:0]           bcd_adj_flat;
    logic [IDX_W-1:0]                  msd_idx;
    logic [VALUE_W-1:0]                raw;
    logic [3:0]                        cur_digit;

    assign raw = $unsigned(value);

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign bcd_adj_flat = bcd_adj;

    // Highest nonzero digit; zero keeps index 0
    always_comb
    begin
        msd_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                msd_idx = IDX_W'(i);
            end
        end
    end

    // Next-state logic of the datapath registers
    always_comb
    begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            neg_next = raw[VALUE_W-1];
            mag_next = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
            bcd_next = '0;
            cnt_next = '0;
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_adj_flat[NUM_DIGITS*4-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.prep)
        begin
            idx_next = msd_idx;
        end
        else if (cmd.dec)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        bcd_reg <= bcd_next;
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Status and output payload
    assign cur_digit        = bcd_reg[idx_reg];
    assign status.conv_last = (cnt_reg == {CNT_W{1'b1}});
    assign status.idx_zero  = (idx_reg == '0);
    assign status.negative  = neg_reg;
    assign char_code        = cmd.emit_sign ? CHR_MINUS : CHR_ZERO + CHAR_W'(cur_digit);
    assign last             = cmd.emit_digit && (idx_reg == '0);

    // Every digit shown is a valid decimal digit
    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (cur_digit <= 4'd9))
        else $error("emitted digit is not decimal");

endmodule

@@ src/sitoa_ctrl.sv @@
// Controller FSM: sequences load, 32 conversion steps, leading-digit search, sign and digit output.
// Depends on sitoa_pkg.
module sitoa_ctrl
    import sitoa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    fsm_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.conv_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                out_valid     = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
                out_valid      = 1'b1;
                if (out_ready)
                begin
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.dec = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted value always starts a conversion
    a_load_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV))
        else $error("transfer in did not start conversion");

    // Final digit transfer returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && status.idx_zero && out_ready) |=> (state_reg == ST_IDLE))
        else $error("last character did not end the item");

    // Input and output never open together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output valid");

    // Sign shows only for negative values
    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign |-> status.negative)
        else $error("minus sign for a non-negative value");

endmodule

@@ src/signed_int_to_decimal_ascii.sv @@
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sitoa_pkg, sitoa_value_if, sitoa_char_if, sitoa_ctrl, sitoa_datapath.
//
//  Channel | Dir | Payload                         | Per transfer
//  --------+-----+---------------------------------+------------------------
//  num     | in  | value[31:0] signed              | one integer
//  text    | out | char_code[5:0], last            | one character, MSB first
//
// An item of N = 1..11 characters runs through an accept, 32 shift-add-3 steps of
// the binary-to-BCD loop (one input bit per cycle), a step to locate the leading
// digit, then one character per cycle while text does not stall.
// The next value is accepted in the cycle after the last character transfer.
// A stall on text holds the current character; nothing else moves.
// Reset (rst_n low, asynchronous) returns the controller to idle.
module signed_int_to_decimal_ascii
    import sitoa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sitoa_value_if.sink  num,
    sitoa_char_if.source text
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sitoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num.valid),
        .in_ready  (num.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sitoa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (num.value),
        .cmd       (cmd),
        .status    (status),
        .char_code (text.char_code),
        .last      (text.last)
    );

endmodule

@@ tb/sv/sitoa_text_checker.sv @@
// Checker for the signed integer to decimal ASCII converter: watches both channels,
// predicts the character text of each accepted value and compares every character.
// Depends on sitoa_pkg, sitoa_value_if, sitoa_char_if.
module sitoa_text_checker
    import sitoa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sitoa_value_if num,
    sitoa_char_if  text,
    output int     fail_count,
    output int     outstanding
);

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } text_char_t;

    localparam logic [VALUE_W-1:0] RADIX = 10;

    text_char_t expected_chars [$];
    int         errors    = 0;
    int         chars_out = 0;

    assign fail_count = errors;

    initial
    begin
        outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] char %0d: %s", $time, chars_out, msg);
        errors++;
    endtask

    // Decimal text of one value, most significant character first
    function automatic void push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit_buf [NUM_DIGITS];
        int                 n_digits;
        text_char_t         ch;
        // magnitude by unsigned negation, so the most negative value needs no special path
        mag      = value[VALUE_W-1] ? (~value + 1'b1) : value;
        n_digits = 0;
        do
        begin
            digit_buf[n_digits] = 4'(mag % RADIX);
            mag = mag / RADIX;
            n_digits++;
        end
        while (mag != 0 && n_digits < NUM_DIGITS);
        if (value[VALUE_W-1])
        begin
            ch.char_code = CHR_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = n_digits - 1; k >= 0; k--)
        begin
            ch.char_code = CHR_ZERO + CHAR_W'(digit_buf[k]);
            ch.last      = (k == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (num.valid && num.ready)
                push_decimal_text(num.value);
            if (text.valid && text.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char_code %0d last %0b",
                                              text.char_code, text.last));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (text.char_code !== want.char_code)
                        report_mismatch($sformatf("char_code %0d, want %0d",
                                                  text.char_code, want.char_code));
                    if (text.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  text.last, want.last));
                end
                chars_out++;
            end
            outstanding <= expected_chars.size();
        end
    end

endmodule

@@ tb/sv/signed_int_to_decimal_ascii_tb.sv @@
// Testbench top for signed_int_to_decimal_ascii: clock, reset, value stimulus,
// output back-pressure, watchdog and verdict.
// Depends on sitoa_pkg, sitoa_value_if, sitoa_char_if, sitoa_text_checker and the DUT.
module signed_int_to_decimal_ascii_tb
    import sitoa_pkg::*;
();

    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_AT      = 150;   // char count at which the receiver holds off
    localparam int HOLD_CYCLES  = 300;
    localparam int SINK_BURST_LO = 500;  // char window with ready held high
    localparam int SINK_BURST_HI = 800;
    localparam int SRC_BURST_LO = 110;   // item window with no sender gaps
    localparam int SRC_BURST_HI = 150;
    localparam int DRAIN_AT     = 90;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_LIMIT  = 2000;

    logic clk;
    logic rst_n;
    bit   sender_burst;
    int   fail_count;
    int   outstanding;

    sitoa_value_if num ();
    sitoa_char_if  text ();

    signed_int_to_decimal_ascii dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num),
        .text  (text)
    );

    sitoa_text_checker text_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .num         (num),
        .text        (text),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Directed values: zero, single digits, decade edges, both extremes, bit patterns
    int directed_vals [21] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
        1000000000, 999999999, -999999999,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'h5555_5555, 32'hAAAA_AAAA,
        1234567890, -1234567890, 4000000
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Random value: mostly a chosen digit count, sometimes all 32 bits at random
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] span;
        int                 n_digits;
        if ($urandom_range(3) == 0)
            return $urandom;
        n_digits = $urandom_range(1, 9);
        span     = 1;
        repeat (n_digits) span = span * 10;
        mag = $urandom % span;
        return $urandom_range(1) ? (~mag + 1'b1) : mag;
    endfunction

    // One value transfer, with random gaps before it
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while (!sender_burst && $urandom_range(99) < IDLE_PCT)
        begin
            num.valid <= 1'b0;
            @(posedge clk);
        end
        num.valid <= 1'b1;
        num.value <= v;
        @(posedge clk);
        while (!num.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        num.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver: random ready, one long hold-off, one stretch with no stalls
    initial
    begin : sink_side
        int  chars_seen;
        bit  held;
        chars_seen = 0;
        held       = 1'b0;
        text.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (text.valid && text.ready)
                chars_seen++;
            if (!held && chars_seen >= HOLD_AT)
            begin
                held = 1'b1;
                text.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (chars_seen >= SINK_BURST_LO && chars_seen < SINK_BURST_HI)
                text.ready <= 1'b1;
            else
                text.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((num.valid && num.ready) || (text.valid && text.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin : source_side
        sender_burst = 1'b0;
        rst_n     <= 1'b0;
        num.valid <= 1'b0;
        num.value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_vals[i])
            send_value(directed_vals[i]);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_burst = (n >= SRC_BURST_LO && n < SRC_BURST_HI);
            if (n == DRAIN_AT)
                wait_drained();
            send_value(random_value());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
